// File: rtl/shs_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared word type, hash constants, control structs, sequencer states and
// the sigma functions used by the schedule and round units.
// ----------------------------------------------------------------------------
package shs_pkg;

   typedef logic [31:0] word_type;

   // Initial hash value H0..H7.
   localparam word_type INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // Round constants, one per round.
   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0] PAD_BYTE  = 8'h80;
   localparam logic [7:0] ZERO_BYTE = 8'h00;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   // Controls for the block buffer and schedule window.
   typedef struct packed {
      logic       push;
      logic [7:0] data;
      logic       step;
      logic       expand;
   } sched_ctrl_type;

   // Controls for the round unit and hash registers.
   typedef struct packed {
      logic init;
      logic load;
      logic step;
      logic fold;
   } round_ctrl_type;

   function automatic word_type big_sigma0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
   endfunction

endpackage

// File: rtl/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream. A last beat pads the message, runs the final block
// and returns the eight digest words, first word first.
//
//   channel  dir  tdata                 tuser           tlast
//   req_     in   data_byte [7:0]       byte_valid      last
//   rsp_     out  digest_word [31:0]    word_index[2:0] last_word
//
// Message bytes are taken one at a time; every full 64-byte block then runs
// 64 rounds plus one fold on the single round unit. A last beat adds the
// pad and length bytes (up to 72), one or two compressions, and eight
// output beats.
// The block takes no input beat while it compresses, pads or emits.
// Reset is synchronous and restores the initial hash and zero counts.
// ----------------------------------------------------------------------------
module sha256_stream_hasher
   import shs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_valid
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast
);

   localparam logic [5:0] FILL_FULL = 6'd63;  // fill before the block's final byte
   localparam logic [5:0] FILL_PAD  = 6'd55;  // fill before the last pad byte
   localparam logic [5:0] RND_LAST  = 6'd63;
   localparam logic [2:0] IDX_LAST  = 3'd7;

   state_type      state_ff, state_in;
   logic [5:0]     fill_ff, fill_in;
   logic [5:0]     rnd_ff, rnd_in;
   logic [2:0]     lcnt_ff, lcnt_in;
   logic [2:0]     widx_ff, widx_in;
   logic [60:0]    bcnt_ff, bcnt_in;
   logic           fin_ff, fin_in;
   logic           pad_first_ff, pad_first_in;
   logic           len_done_ff, len_done_in;

   sched_ctrl_type sc;
   round_ctrl_type rc;
   word_type       w_t;
   word_type       digest;
   logic [63:0]    len_shift;

   // Length bytes go out most significant first.
   assign len_shift = {bcnt_ff, 3'b000} << {lcnt_ff, 3'b000};

   shs_sched u_sched (
      .clock (clock),
      .ctrl  (sc),
      .w_out (w_t)
   );

   shs_round u_round (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (rc),
      .k_in        (ROUND_K[rnd_ff]),
      .w_in        (w_t),
      .word_sel    (widx_ff),
      .digest_word (digest)
   );

   // Sequencer state and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rnd_ff       <= '0;
         lcnt_ff      <= '0;
         widx_ff      <= '0;
         bcnt_ff      <= '0;
         fin_ff       <= 1'b0;
         pad_first_ff <= 1'b0;
         len_done_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rnd_ff       <= rnd_in;
         lcnt_ff      <= lcnt_in;
         widx_ff      <= widx_in;
         bcnt_ff      <= bcnt_in;
         fin_ff       <= fin_in;
         pad_first_ff <= pad_first_in;
         len_done_ff  <= len_done_in;
      end
   end

   // Next state and unit controls.
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      rnd_in       = rnd_ff;
      lcnt_in      = lcnt_ff;
      widx_in      = widx_ff;
      bcnt_in      = bcnt_ff;
      fin_in       = fin_ff;
      pad_first_in = pad_first_ff;
      len_done_in  = len_done_ff;
      sc           = '0;
      rc           = '0;
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser) begin
                  sc.push = 1'b1;
                  sc.data = req_tdata;
                  bcnt_in = bcnt_ff + 61'd1;
                  fill_in = fill_ff + 6'd1;
               end
               if (req_tlast) begin
                  fin_in       = 1'b1;
                  pad_first_in = 1'b1;
               end
               if (req_tuser && fill_ff == FILL_FULL) begin
                  rc.load  = 1'b1;
                  rnd_in   = '0;
                  state_in = ST_ROUND;
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end
            end
         end

         ST_PAD: begin
            sc.push      = 1'b1;
            sc.data      = pad_first_ff ? PAD_BYTE : ZERO_BYTE;
            pad_first_in = 1'b0;
            fill_in      = fill_ff + 6'd1;
            if (fill_ff == FILL_FULL) begin
               rc.load  = 1'b1;
               rnd_in   = '0;
               state_in = ST_ROUND;
            end else if (fill_ff == FILL_PAD) begin
               lcnt_in  = '0;
               state_in = ST_LEN;
            end
         end

         ST_LEN: begin
            sc.push = 1'b1;
            sc.data = len_shift[63:56];
            lcnt_in = lcnt_ff + 3'd1;
            fill_in = fill_ff + 6'd1;
            if (lcnt_ff == IDX_LAST) begin
               len_done_in = 1'b1;
               rc.load     = 1'b1;
               rnd_in      = '0;
               state_in    = ST_ROUND;
            end
         end

         ST_ROUND: begin
            rc.step   = 1'b1;
            sc.step   = 1'b1;
            sc.expand = (rnd_ff[5:4] != 2'b00);
            rnd_in    = rnd_ff + 6'd1;
            if (rnd_ff == RND_LAST) begin
               state_in = ST_FOLD;
            end
         end

         ST_FOLD: begin
            rc.fold = 1'b1;
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (len_done_ff) begin
               widx_in  = '0;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_PAD;
            end
         end

         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               widx_in = widx_ff + 3'd1;
               if (widx_ff == IDX_LAST) begin
                  rc.init     = 1'b1;
                  fin_in      = 1'b0;
                  len_done_in = 1'b0;
                  bcnt_in     = '0;
                  state_in    = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tdata = digest;
   assign rsp_tuser = widx_ff;
   assign rsp_tlast = (widx_ff == IDX_LAST);

   // The input and output sides never run at the same time.
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while digest beats are pending");

   // A digest always starts with word zero.
   a_first_word: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> (rsp_tuser == 3'd0))
      else $error("digest did not start at word zero");

   // After the final digest beat the block takes input again.
   a_back_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("block not ready after the final digest beat");

   // The last round is always followed by the fold.
   a_fold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && rnd_ff == RND_LAST) |=> (state_ff == ST_FOLD))
      else $error("fold did not follow the last round");

endmodule

// File: rtl/shs_sched.sv
// ----------------------------------------------------------------------------
// SHA-256 block buffer and message schedule
// A sixteen-word window that takes message bytes one at a time and then,
// during compression, shifts one word per round and, from round 16 on,
// expands the schedule. The oldest word always sits in entry zero.
// ----------------------------------------------------------------------------
module shs_sched
   import shs_pkg::*;
(
   input  logic           clock,
   input  sched_ctrl_type ctrl,
   output word_type       w_out
);

   word_type win_ff [16];
   word_type win_in [16];
   word_type w_new;

   // Schedule expansion from the fixed taps of the window.
   always_comb begin
      w_new = win_ff[0] + small_sigma0(win_ff[1]) + win_ff[9] + small_sigma1(win_ff[14]);
      w_out = ctrl.expand ? w_new : win_ff[0];
   end

   // Byte shift during fill, word shift during rounds.
   always_comb begin
      win_in = win_ff;
      if (ctrl.push) begin
         for (int k = 0; k < 15; k++) begin
            win_in[k] = {win_ff[k][23:0], win_ff[k+1][31:24]};
         end
         win_in[15] = {win_ff[15][23:0], ctrl.data};
      end else if (ctrl.step) begin
         for (int k = 0; k < 15; k++) begin
            win_in[k] = win_ff[k+1];
         end
         win_in[15] = w_out;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

// File: rtl/shs_round.sv
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Holds the hash words and the working variables a..h. One compression
// round per step; the fold adds the working variables back into the hash.
// ----------------------------------------------------------------------------
module shs_round
   import shs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  round_ctrl_type ctrl,
   input  word_type       k_in,
   input  word_type       w_in,
   input  logic [2:0]     word_sel,
   output word_type       digest_word
);

   word_type hash_ff [8];
   word_type hash_in [8];
   word_type vars_ff [8];
   word_type vars_in [8];
   word_type ch;
   word_type maj;
   word_type t1;
   word_type t2;

   // One round of the compression function.
   always_comb begin
      ch  = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
      maj = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2]) ^ (vars_ff[1] & vars_ff[2]);
      t1  = vars_ff[7] + big_sigma1(vars_ff[4]) + ch + k_in + w_in;
      t2  = big_sigma0(vars_ff[0]) + maj;
   end

   // Working variables: loaded from the hash at block start, then rotated.
   always_comb begin
      vars_in = vars_ff;
      if (ctrl.load) begin
         vars_in = hash_ff;
      end else if (ctrl.step) begin
         vars_in[7] = vars_ff[6];
         vars_in[6] = vars_ff[5];
         vars_in[5] = vars_ff[4];
         vars_in[4] = vars_ff[3] + t1;
         vars_in[3] = vars_ff[2];
         vars_in[2] = vars_ff[1];
         vars_in[1] = vars_ff[0];
         vars_in[0] = t1 + t2;
      end
   end

   // Hash words: fold after the last round, back to the initial value after emit.
   always_comb begin
      hash_in = hash_ff;
      if (ctrl.init) begin
         hash_in = INIT_HASH;
      end else if (ctrl.fold) begin
         for (int j = 0; j < 8; j++) begin
            hash_in[j] = hash_ff[j] + vars_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= INIT_HASH;
      end else begin
         hash_ff <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      vars_ff <= vars_in;
   end

   assign digest_word = hash_ff[word_sel];

endmodule
